@@ rtl/lot_pkg.sv @@
// ----------------------------------------------------------------------------
// lot_pkg
// Shared types and constants of the recency order tracker: the request and
// response payloads, the operation codes and the records passed between
// the cells of the order chain.
// ----------------------------------------------------------------------------
package lot_pkg;

   // Number of keys held, and the width of a stored key.
   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;

   // Width of the held-key counter, which must reach CAPACITY itself.
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // Operation codes of a request.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Request payload.
   typedef struct packed {
      logic        op;
      logic [31:0] key;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic        hit;
      logic        evicted_valid;
      logic [31:0] evicted_key;
      logic        was_empty;
      logic [4:0]  occupancy;
   } rsp_type;

   // Broadcast to every cell for the request being taken.
   typedef struct packed {
      logic                 fire;
      logic                 op;
      logic [KEY_WIDTH-1:0] key;
   } cell_ctrl_type;

   // Passed from a cell to its less recent neighbour.
   typedef struct packed {
      logic                 valid;
      logic [KEY_WIDTH-1:0] key;
   } cell_fwd_type;

   // Passed from a cell to its more recent neighbour.
   typedef struct packed {
      logic                 valid;
      logic                 match_any;
      logic [KEY_WIDTH-1:0] tail_key;
   } cell_back_type;

endpackage

@@ rtl/lot_cell.sv @@
// ----------------------------------------------------------------------------
// lot_cell
// One position of the recency chain. It holds one key and its valid bit,
// compares the key against the request, takes the entry of its more recent
// neighbour when an access shifts it, and empties if it is the removed tail.
// ----------------------------------------------------------------------------
module lot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lot_pkg::cell_ctrl_type ctrl,
   input  logic                   hit_any,
   input  lot_pkg::cell_fwd_type  fwd_in,
   input  lot_pkg::cell_back_type back_in,
   output lot_pkg::cell_fwd_type  fwd_out,
   output lot_pkg::cell_back_type back_out
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [lot_pkg::KEY_WIDTH-1:0] key_ff;
   logic [lot_pkg::KEY_WIDTH-1:0] key_in;
   logic                          match;
   logic                          is_tail;
   logic                          shift;
   logic                          clear;

   // Compare and find whether this cell is the least recent valid one.
   assign match   = valid_ff & (key_ff == ctrl.key);
   assign is_tail = valid_ff & ~back_in.valid;

   // Results gathered towards the most recent end of the chain.
   assign back_out.valid     = valid_ff;
   assign back_out.match_any = match | back_in.match_any;
   assign back_out.tail_key  = back_in.tail_key | (is_tail ? key_ff : '0);

   assign fwd_out.valid = valid_ff;
   assign fwd_out.key   = key_ff;

   // An access shifts every cell on a miss, and on a hit only the cells up
   // to and including the matching one. A removal drops the tail cell.
   assign shift = ctrl.fire & (ctrl.op == lot_pkg::OP_ACCESS)
                  & (~hit_any | back_out.match_any);
   assign clear = ctrl.fire & (ctrl.op == lot_pkg::OP_REMOVE) & is_tail;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (shift) begin
         valid_in = fwd_in.valid;
         key_in   = fwd_in.key;
      end else if (clear) begin
         valid_in = 1'b0;
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stored key.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

@@ rtl/lru_order_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// lru_order_tracker_unit
// Least recently used tracker built as a chain of cells in recency order.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns its response from
// a registered stage in the next cycle; a new request is taken while the
// previous response waits, as long as the response side is not stalled.
// The figure is set by the cell chain: every cell compares its key with
// the request at once, and the chain shifts by one position in the same
// cycle, so the most recent key sits in the first cell and the least
// recent in the last valid one. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module lru_order_tracker_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lot_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lot_pkg::rsp_type rsp_data
);

   lot_pkg::cell_ctrl_type                 ctrl;
   lot_pkg::cell_fwd_type                  fwd  [0:lot_pkg::CAPACITY];
   lot_pkg::cell_back_type                 back [0:lot_pkg::CAPACITY];
   logic                                   fire;
   logic                                   hit_any;
   logic                                   full;
   logic                                   empty;
   logic [lot_pkg::COUNT_WIDTH-1:0]        count_ff;
   logic [lot_pkg::COUNT_WIDTH-1:0]        count_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   lot_pkg::rsp_type                       rsp_ff;
   lot_pkg::rsp_type                       rsp_in;

   // Handshake: the response register frees up when it is taken.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign fire      = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Request broadcast to the cells.
   assign ctrl.fire = fire;
   assign ctrl.op   = req_data.op;
   assign ctrl.key  = lot_pkg::KEY_WIDTH'(req_data.key);

   // Ends of the chain: the request enters at the most recent end.
   assign fwd[0].valid                      = 1'b1;
   assign fwd[0].key                        = lot_pkg::KEY_WIDTH'(req_data.key);
   assign back[lot_pkg::CAPACITY].valid     = 1'b0;
   assign back[lot_pkg::CAPACITY].match_any = 1'b0;
   assign back[lot_pkg::CAPACITY].tail_key  = '0;

   // The row of cells.
   for (genvar i = 0; i < lot_pkg::CAPACITY; i++) begin : g_cell
      lot_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .hit_any  (hit_any),
         .fwd_in   (fwd[i]),
         .back_in  (back[i+1]),
         .fwd_out  (fwd[i+1]),
         .back_out (back[i])
      );
   end

   assign hit_any = back[0].match_any;
   assign full    = fwd[lot_pkg::CAPACITY].valid;
   assign empty   = ~fwd[1].valid;

   // Response and next key count.
   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      if (req_data.op == lot_pkg::OP_ACCESS) begin
         rsp_in.hit = hit_any;
         if (!hit_any) begin
            if (full) begin
               rsp_in.evicted_valid = 1'b1;
               rsp_in.evicted_key   = 32'(fwd[lot_pkg::CAPACITY].key);
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end else begin
         rsp_in.was_empty = empty;
         if (!empty) begin
            rsp_in.evicted_valid = 1'b1;
            rsp_in.evicted_key   = 32'(back[0].tail_key);
            count_in             = count_ff - 1'b1;
         end
      end
      rsp_in.occupancy = 5'(count_in);
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ tb/sv/lru_order_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lru_order_tracker_unit_tb
// Self-checking bench for the least recently used tracker. A shadow copy of
// the recency order works out the response of every request taken. A short
// table of directed requests runs first, followed by several hundred random
// accesses and removals. Random idle and stall bursts fall on both sides,
// and there is one long response-side hold-off that backs up the input.
// ----------------------------------------------------------------------------
module lru_order_tracker_unit_tb;

   localparam int RANK_W       = $clog2(lot_pkg::CAPACITY);
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_TAIL   = 60;
   localparam int POOL_SIZE    = 24;
   localparam int HOLD_CYCLES  = 80;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   lot_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   lot_pkg::rsp_type rsp_data;

   // Directed table row: a request and, where obvious, its typed response.
   typedef struct {
      lot_pkg::req_type stim;
      bit               fixed;
      lot_pkg::rsp_type want;
   } dir_row_type;

   dir_row_type dir_table[$];

   // Shadow copy of the recency order.
   logic [31:0]       shadow_key[lot_pkg::CAPACITY];
   logic              shadow_valid[lot_pkg::CAPACITY];
   logic [RANK_W-1:0] shadow_rank[lot_pkg::CAPACITY];
   logic [4:0]        shadow_count;

   lot_pkg::rsp_type awaiting_rsp[$];
   int        mismatch_count = 0;
   int        stray_count    = 0;
   int        reports_shown  = 0;
   int        rsp_seen       = 0;
   bit        idle_on        = 1'b1;
   bit        hold_off_request = 1'b0;
   logic [31:0] key_pool[POOL_SIZE];

   lru_order_tracker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Slot of the least recent held key.
   function automatic int oldest_entry();
      int best;
      best = -1;
      for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
         if (shadow_valid[i] && (best < 0 || shadow_rank[i] >= shadow_rank[best])) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Applies one request to the shadow order and returns its response.
   function automatic lot_pkg::rsp_type lru_step(input lot_pkg::req_type r);
      lot_pkg::rsp_type  res;
      int                found;
      int                slot;
      logic [RANK_W-1:0] hit_rank;
      res   = '0;
      found = -1;
      slot  = -1;
      if (r.op == lot_pkg::OP_ACCESS) begin
         for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == r.key) begin
               found = i;
            end
         end
         if (found >= 0) begin
            // Hit: the keys more recent than this one age by one.
            res.hit  = 1'b1;
            hit_rank = shadow_rank[found];
            for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
               if (shadow_valid[i] && shadow_rank[i] < hit_rank) begin
                  shadow_rank[i] = shadow_rank[i] + 1'b1;
               end
            end
            shadow_rank[found] = '0;
         end else begin
            // Miss: a full store gives up its least recent key first.
            if (shadow_count == lot_pkg::CAPACITY) begin
               slot                = oldest_entry();
               res.evicted_valid   = 1'b1;
               res.evicted_key     = shadow_key[slot];
               shadow_valid[slot]  = 1'b0;
               shadow_count        = shadow_count - 1'b1;
            end else begin
               for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
                  if (slot < 0 && !shadow_valid[i]) begin
                     slot = i;
                  end
               end
            end
            for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
               if (shadow_valid[i]) begin
                  shadow_rank[i] = shadow_rank[i] + 1'b1;
               end
            end
            shadow_key[slot]   = r.key;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = '0;
            shadow_count       = shadow_count + 1'b1;
         end
      end else begin
         if (shadow_count == 0) begin
            res.was_empty = 1'b1;
         end else begin
            slot               = oldest_entry();
            res.evicted_valid  = 1'b1;
            res.evicted_key    = shadow_key[slot];
            shadow_valid[slot] = 1'b0;
            shadow_rank[slot]  = '0;
            shadow_count       = shadow_count - 1'b1;
         end
      end
      res.occupancy = shadow_count;
      return res;
   endfunction

   function automatic lot_pkg::rsp_type mk_rsp(input logic hit, input logic ev_valid,
                                               input logic [31:0] ev_key,
                                               input logic empty,
                                               input logic [4:0] occ);
      lot_pkg::rsp_type res;
      res.hit           = hit;
      res.evicted_valid = ev_valid;
      res.evicted_key   = ev_key;
      res.was_empty     = empty;
      res.occupancy     = occ;
      return res;
   endfunction

   function automatic lot_pkg::req_type mk_req(input logic op, input logic [31:0] key);
      lot_pkg::req_type r;
      r.op  = op;
      r.key = key;
      return r;
   endfunction

   task automatic add_row(input logic op, input logic [31:0] key, input bit fixed,
                          input lot_pkg::rsp_type want);
      dir_row_type row;
      row.stim  = mk_req(op, key);
      row.fixed = fixed;
      row.want  = want;
      dir_table.push_back(row);
   endtask

   // Offers one request, with an optional idle burst first, and records the
   // response it should produce once the request has been taken.
   task automatic offer(input lot_pkg::req_type r, input bit fixed,
                        input lot_pkg::rsp_type want);
      lot_pkg::req_type junk;
      lot_pkg::rsp_type predicted;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         junk.op   = 1'($urandom_range(0, 1));
         junk.key  = $urandom;
         req_valid <= 1'b0;
         req_data  <= junk;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = lru_step(r);
      awaiting_rsp.push_back(fixed ? want : predicted);
   endtask

   // Response side: random stall bursts, and one long hold-off on request.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compares every response taken with the oldest one still awaited.
   always @(posedge clock) begin : rsp_check
      lot_pkg::rsp_type want;
      bit               bad;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         rsp_seen++;
         if (awaiting_rsp.size() == 0) begin
            stray_count++;
            if (reports_shown < 10) begin
               reports_shown++;
               $display("unexpected response %0d: %p", rsp_seen, rsp_data);
            end
         end else begin
            want = awaiting_rsp.pop_front();
            bad  = (rsp_data.hit !== want.hit)
                || (rsp_data.evicted_valid !== want.evicted_valid)
                || (rsp_data.evicted_key !== want.evicted_key)
                || (rsp_data.was_empty !== want.was_empty)
                || (rsp_data.occupancy !== want.occupancy);
            if (bad) begin
               mismatch_count++;
               if (reports_shown < 10) begin
                  reports_shown++;
                  $display("mismatch on response %0d:", rsp_seen);
                  $display("  expected hit %b evicted %b key %h empty %b occupancy %0d",
                           want.hit, want.evicted_valid, want.evicted_key,
                           want.was_empty, want.occupancy);
                  $display("  actual   hit %b evicted %b key %h empty %b occupancy %0d",
                           rsp_data.hit, rsp_data.evicted_valid, rsp_data.evicted_key,
                           rsp_data.was_empty, rsp_data.occupancy);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      lot_pkg::req_type r;
      int               waited;
      int               remove_odds;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
         shadow_key[i]   = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = '0;
      end
      shadow_count = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end

      // Removal from an empty store, the key extremes, hits on the most and the
      // least recent key, and draining back to empty.
      add_row(lot_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
              mk_rsp(1'b0, 1'b0, 32'h0, 1'b1, 5'd0));
      add_row(lot_pkg::OP_ACCESS, 32'h0000_0000, 1'b1,
              mk_rsp(1'b0, 1'b0, 32'h0, 1'b0, 5'd1));
      add_row(lot_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1,
              mk_rsp(1'b0, 1'b0, 32'h0, 1'b0, 5'd2));
      add_row(lot_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1,
              mk_rsp(1'b1, 1'b0, 32'h0, 1'b0, 5'd2));
      add_row(lot_pkg::OP_ACCESS, 32'h0000_0000, 1'b1,
              mk_rsp(1'b1, 1'b0, 32'h0, 1'b0, 5'd2));
      add_row(lot_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1,
              mk_rsp(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 5'd1));
      add_row(lot_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
              mk_rsp(1'b0, 1'b1, 32'h0, 1'b0, 5'd0));
      add_row(lot_pkg::OP_REMOVE, 32'h1234_5678, 1'b1,
              mk_rsp(1'b0, 1'b0, 32'h0, 1'b1, 5'd0));
      // Fill the store, then miss on a full store, hit in the middle of a
      // full store, and remove the least recent key.
      for (int i = 0; i < lot_pkg::CAPACITY; i++) begin
         add_row(lot_pkg::OP_ACCESS, 32'h0101_0101 * (i + 1), 1'b0, '0);
      end
      add_row(lot_pkg::OP_ACCESS, 32'hA5A5_5A5A, 1'b1,
              mk_rsp(1'b0, 1'b1, 32'h0101_0101, 1'b0, 5'd16));
      add_row(lot_pkg::OP_ACCESS, 32'h0909_0909, 1'b0, '0);
      add_row(lot_pkg::OP_REMOVE, 32'h0, 1'b1,
              mk_rsp(1'b0, 1'b1, 32'h0202_0202, 1'b0, 5'd15));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[n]) begin
         offer(dir_table[n].stim, dir_table[n].fixed, dir_table[n].want);
      end

      // Random part: the share of removals changes by segment so the store
      // fills, churns and drains; most keys come from a small pool.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 40) % 4 != 3);
         if (n == 200) begin
            hold_off_request = 1'b1;
         end
         case ((n / 60) % 3)
            0:       remove_odds = 8;
            1:       remove_odds = 2;
            default: remove_odds = 4;
         endcase
         r.op  = ($urandom_range(1, remove_odds) == 1) ? lot_pkg::OP_REMOVE
                                                        : lot_pkg::OP_ACCESS;
         r.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
         offer(r, 1'b0, '0);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (awaiting_rsp.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (awaiting_rsp.size() != 0) begin
         $display("lru_order_tracker_unit regression: fail");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         if (mismatch_count == 0 && stray_count == 0 && awaiting_rsp.size() == 0) begin
            $display("lru_order_tracker_unit regression: pass");
         end else begin
            $display("lru_order_tracker_unit regression: fail");
         end
         $finish;
      end
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("lru_order_tracker_unit regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lot_pkg.sv
rtl/lot_cell.sv
rtl/lru_order_tracker_unit.sv
tb/sv/lru_order_tracker_unit_tb.sv
